### rtl/brcc_pkg.sv
// ---------------------------------------------------------------------------
// brcc_pkg: shared types and constants of the balance controller
// Fixed field widths, loop limits, register indexes, sequencer states and
// the operand bundle of the gain-serial multiply-accumulate unit.
// ---------------------------------------------------------------------------
package brcc_pkg;

  // Gain-serial multiply-accumulate unit
  localparam int GAIN_W    = 32;
  localparam int MAC_XW    = 32;
  localparam int MAC_AW    = MAC_XW + 2;
  localparam int MAC_PW    = MAC_AW + GAIN_W;
  localparam int MAC_STEPS = GAIN_W;
  localparam int MAC_CW    = $clog2(MAC_STEPS);

  // Low-pass filter divide by ten, one quotient bit per cycle
  localparam int NUM_W     = 21;
  localparam int MAG_W     = NUM_W - 1;
  localparam int FE_W      = 18;
  localparam int DIV_STEPS = MAG_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS);
  localparam int FILT_DEN  = 10;
  localparam int REM_W     = 4;

  // Loop limits
  localparam int SPEED_FWD_MAX  = 15;
  localparam int SPEED_TURN_MAX = 80;
  localparam int TURN_STEP      = 30;
  localparam int NEAR_DISTANCE  = 50;
  localparam int INTEGRAL_MAX   = 10000;
  localparam int DIFF_MAX       = 1073741824;

  // Register reset values
  localparam int          BAL_ANGLE_RST  = -1485;
  localparam logic [31:0] UPRIGHT_KP_RST = 32'd18350080;
  localparam logic [31:0] UPRIGHT_KD_RST = 32'd75366;
  localparam logic [31:0] SPEED_KP_RST   = 32'd19661;
  localparam logic [31:0] SPEED_KI_RST   = 32'd98;
  localparam logic [31:0] STEER_KP_RST   = 32'd0;
  localparam logic [31:0] STEER_KD_RST   = 32'd0;
  localparam logic [15:0] PWM_LIMIT_RST  = 16'd7200;

  typedef enum logic [2:0] {
    CFG_BALANCE_ANGLE = 3'd0,
    CFG_UPRIGHT_KP    = 3'd1,
    CFG_UPRIGHT_KD    = 3'd2,
    CFG_SPEED_KP      = 3'd3,
    CFG_SPEED_KI      = 3'd4,
    CFG_STEER_KP      = 3'd5,
    CFG_STEER_KD      = 3'd6,
    CFG_PWM_LIMIT     = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_NUM,
    ST_DIV_GO,
    ST_DIV_RUN,
    ST_INTG,
    ST_VT_GO,
    ST_VT_RUN,
    ST_DIFF,
    ST_U_GO,
    ST_U_RUN,
    ST_MIX
  } st_e;

  // Operands of one two-product accumulate: ga * xa + gb * xb
  typedef struct packed {
    logic signed [MAC_XW-1:0] xa;
    logic signed [MAC_XW-1:0] xb;
    logic        [GAIN_W-1:0] ga;
    logic        [GAIN_W-1:0] gb;
  } mac_op_t;

endpackage

### rtl/brcc_div10.sv
// ---------------------------------------------------------------------------
// brcc_div10: signed divide by ten, truncated toward zero
// Restoring division of the magnitude, one quotient bit per cycle with a
// narrow remainder register; the sign is applied at the output.
// ---------------------------------------------------------------------------
module brcc_div10 (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [brcc_pkg::NUM_W-1:0]  num_i,
  output logic                               done_o,
  output logic signed [brcc_pkg::FE_W-1:0]   quot_o
);

  localparam int NW = brcc_pkg::NUM_W;
  localparam int MW = brcc_pkg::MAG_W;
  localparam int FW = brcc_pkg::FE_W;
  localparam int CW = brcc_pkg::DIV_CW;
  localparam int RW = brcc_pkg::REM_W;
  localparam int TW = RW + 1;

  logic          neg_q;
  logic [MW-1:0] mag_q;
  logic [MW-1:0] quo_q;
  logic [RW-1:0] rem_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  logic [NW-1:0] abs_num;
  logic [TW-1:0] trial;
  logic          ge;
  logic [FW-1:0] qmag;

  always_comb begin
    abs_num = num_i[NW-1] ? NW'(-num_i) : num_i;
    trial   = {rem_q, mag_q[MW-1]};
    ge      = (trial >= TW'(brcc_pkg::FILT_DEN));
    qmag    = {1'b0, quo_q[FW-2:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(brcc_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift the magnitude out MSB first, quotient bits in at the LSB
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NW-1];
      mag_q <= abs_num[MW-1:0];
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      mag_q <= {mag_q[MW-2:0], 1'b0};
      rem_q <= ge ? RW'(trial - TW'(brcc_pkg::FILT_DEN)) : trial[RW-1:0];
      quo_q <= {quo_q[MW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(qmag) : $signed(qmag);

endmodule

### rtl/brcc_mac.sv
// ---------------------------------------------------------------------------
// brcc_mac: gain-serial two-product multiply-accumulate
// Forms ga * xa + gb * xb with unsigned gains and signed operands, one gain
// bit per cycle; the low product bits leave through a shift register.
// ---------------------------------------------------------------------------
module brcc_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  brcc_pkg::mac_op_t                  op_i,
  output logic                               done_o,
  output logic signed [brcc_pkg::MAC_PW-1:0] prod_o
);

  localparam int XW = brcc_pkg::MAC_XW;
  localparam int AW = brcc_pkg::MAC_AW;
  localparam int GW = brcc_pkg::GAIN_W;
  localparam int CW = brcc_pkg::MAC_CW;

  logic        [GW-1:0] ga_q;
  logic        [GW-1:0] gb_q;
  logic signed [XW-1:0] xa_q;
  logic signed [XW-1:0] xb_q;
  logic signed [AW-1:0] hi_q;
  logic        [GW-1:0] lo_q;
  logic        [CW-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic signed [AW-1:0] sum;

  always_comb begin
    sum = hi_q;
    if (ga_q[0]) begin
      sum = sum + AW'(xa_q);
    end
    if (gb_q[0]) begin
      sum = sum + AW'(xb_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(brcc_pkg::MAC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Add the selected operands into the high part, then shift one bit down
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ga_q <= op_i.ga;
      gb_q <= op_i.gb;
      xa_q <= op_i.xa;
      xb_q <= op_i.xb;
      hi_q <= '0;
      lo_q <= '0;
    end else if (busy_q) begin
      ga_q <= {1'b0, ga_q[GW-1:1]};
      gb_q <= {1'b0, gb_q[GW-1:1]};
      hi_q <= {sum[AW-1], sum[AW-1:1]};
      lo_q <= {sum[0], lo_q[GW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

### rtl/balance_robot_cascaded_controller.sv
// ---------------------------------------------------------------------------
// balance_robot_cascaded_controller: two-wheel balance cascaded controller
// Per control tick: ramp the forward and turn targets, filter the wheel
// speed error, run the velocity PI, upright PD and turn PD stages and mix
// the two motor drives, each clamped to +-pwm_limit.
//
//   channel  | direction | handshake                    | payload
//   ---------+-----------+------------------------------+---------------------
//   s_axis   | in        | s_axis_tvalid/s_axis_tready  | one control tick
//   m_axis   | out       | m_axis_tvalid/m_axis_tready  | both motor drives
//   cfg      | in        | cfg_we_i (no wait)           | gains, angle, limit
//
// - From request acceptance to result the sequencer runs the divide-by-ten
//   of the filter, the velocity and turn products (two units side by side)
//   and the upright product, with register steps between them.
// - The 32 gain bits, taken one per cycle by the multiply-accumulate
//   units, set the length of each product pass.
// - One request at a time; the next one is taken the cycle after a result
//   enters the output register, even while that result still waits.
// - A stalled output holds the sequencer in its last step.
// - Reset clears the targets, the filter and the integral, and loads the
//   register defaults; no clearing pass.
// ---------------------------------------------------------------------------
module balance_robot_cascaded_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i,
  // control tick in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // from bit 0: enc_left[16], enc_right[16], pitch[17], rate_pitch[16],
  // rate_yaw[16], cmd_fore, cmd_back, cmd_left, cmd_right, distance[8],
  // stop_request, zero fill
  input  logic [95:0] s_axis_tdata,
  // motor drives out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // from bit 0: drive_left[17], drive_right[17], zero fill
  output logic [39:0] m_axis_tdata
);

  localparam int PW = brcc_pkg::MAC_PW;

  localparam logic signed [5:0]  FWD_MAX   = 6'(brcc_pkg::SPEED_FWD_MAX);
  localparam logic signed [9:0]  TURN_MAX  = 10'(brcc_pkg::SPEED_TURN_MAX);
  localparam logic signed [9:0]  TURN_STEP = 10'(brcc_pkg::TURN_STEP);
  localparam logic        [7:0]  NEAR_DIST = 8'(brcc_pkg::NEAR_DISTANCE);
  localparam logic signed [18:0] INT_MAX   = 19'(brcc_pkg::INTEGRAL_MAX);
  localparam logic signed [46:0] DIFF_MAX  = 47'(brcc_pkg::DIFF_MAX);

  // ------------------------------------------------------------------
  // Input field decode
  // ------------------------------------------------------------------
  logic signed [15:0] in_enc_left;
  logic signed [15:0] in_enc_right;
  logic signed [16:0] in_pitch;
  logic signed [15:0] in_rate_pitch;
  logic signed [15:0] in_rate_yaw;
  logic               in_fore;
  logic               in_back;
  logic               in_left;
  logic               in_right;
  logic        [7:0]  in_distance;
  logic               in_stop;
  logic               in_req;

  assign in_enc_left   = s_axis_tdata[15:0];
  assign in_enc_right  = s_axis_tdata[31:16];
  assign in_pitch      = s_axis_tdata[48:32];
  assign in_rate_pitch = s_axis_tdata[64:49];
  assign in_rate_yaw   = s_axis_tdata[80:65];
  assign in_fore       = s_axis_tdata[81];
  assign in_back       = s_axis_tdata[82];
  assign in_left       = s_axis_tdata[83];
  assign in_right      = s_axis_tdata[84];
  assign in_distance   = s_axis_tdata[92:85];
  assign in_stop       = s_axis_tdata[93];

  // ------------------------------------------------------------------
  // Registers
  // ------------------------------------------------------------------
  brcc_pkg::st_e      state_q, state_d;

  logic signed [16:0] bal_angle_q;
  logic        [31:0] upright_kp_q;
  logic        [31:0] upright_kd_q;
  logic        [31:0] speed_kp_q;
  logic        [31:0] speed_ki_q;
  logic        [31:0] steer_kp_q;
  logic        [31:0] steer_kd_q;
  logic        [15:0] pwm_limit_q;

  logic signed [4:0]  tgt_speed_q, tgt_speed_d;
  logic signed [7:0]  turn_speed_q, turn_speed_d;
  logic signed [17:0] filt_err_q, filt_err_d;
  logic signed [14:0] err_int_q, err_int_d;
  logic               out_valid_q, out_valid_d;

  logic signed [15:0] enc_left_q;
  logic signed [15:0] enc_right_q;
  logic signed [16:0] pitch_q;
  logic signed [15:0] rate_pitch_q;
  logic signed [15:0] rate_yaw_q;
  logic               turn_cmd_q;
  logic               stop_q;
  logic signed [17:0] err_q;
  logic signed [20:0] num_q;
  logic signed [36:0] v_q;
  logic signed [33:0] t_q;
  logic signed [31:0] diff_q;
  logic signed [40:0] u_q;
  logic signed [16:0] drive_left_q;
  logic signed [16:0] drive_right_q;

  // ------------------------------------------------------------------
  // Datapath step logic
  // ------------------------------------------------------------------
  logic signed [5:0]  ts_step;
  logic signed [4:0]  tgt_next;
  logic signed [9:0]  tn_step;
  logic signed [7:0]  turn_next;
  logic signed [17:0] err_calc;
  logic signed [20:0] e21, f21, num_calc;
  logic signed [18:0] isum;
  logic signed [14:0] int_calc;
  logic signed [36:0] v_calc;
  logic signed [33:0] t_calc;
  logic signed [40:0] u_calc;
  logic signed [46:0] setpoint, dd;
  logic signed [31:0] diff_calc;
  logic signed [41:0] mix_u, mix_t, mix_lim;
  logic signed [16:0] left_calc, right_calc;

  logic                              div_start;
  logic                              div_done;
  logic signed [brcc_pkg::FE_W-1:0]  div_quot;
  logic                              mac_a_start;
  logic                              mac_b_start;
  logic                              mac_a_done;
  logic                              mac_b_done;
  brcc_pkg::mac_op_t                 mac_a_op;
  brcc_pkg::mac_op_t                 mac_b_op;
  logic signed [PW-1:0]              prod_a;
  logic signed [PW-1:0]              prod_b;
  logic                              out_load;

  function automatic logic signed [41:0] clamp_lim(input logic signed [41:0] x,
                                                   input logic signed [41:0] lim);
    logic signed [41:0] r;
    r = x;
    if (x > lim) begin
      r = lim;
    end else if (x < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  // Forward target: ramp by one, reverse the ramp when backing near an obstacle
  always_comb begin
    ts_step = 6'(tgt_speed_q);
    if (!in_fore && !in_back) begin
      ts_step = '0;
    end else if (in_fore && !in_back) begin
      ts_step = 6'(tgt_speed_q) - 6'sd1;
    end else if (in_back && !in_fore) begin
      if (in_distance < NEAR_DIST) begin
        ts_step = 6'(tgt_speed_q) - 6'sd1;
      end else begin
        ts_step = 6'(tgt_speed_q) + 6'sd1;
      end
    end
    if (ts_step > FWD_MAX) begin
      ts_step = FWD_MAX;
    end else if (ts_step < -FWD_MAX) begin
      ts_step = -FWD_MAX;
    end
    tgt_next = 5'(ts_step);
  end

  // Turn target: step per flag, drop to zero with no flag
  always_comb begin
    tn_step = 10'(turn_speed_q);
    if (!in_left && !in_right) begin
      tn_step = '0;
    end else begin
      if (in_left) begin
        tn_step = tn_step + TURN_STEP;
      end
      if (in_right) begin
        tn_step = tn_step - TURN_STEP;
      end
    end
    if (tn_step > TURN_MAX) begin
      tn_step = TURN_MAX;
    end else if (tn_step < -TURN_MAX) begin
      tn_step = -TURN_MAX;
    end
    turn_next = 8'(tn_step);
  end

  // Speed error, filter numerator 3*err + 7*filtered, integral update
  always_comb begin
    err_calc = 18'(enc_left_q) + 18'(enc_right_q) - 18'(tgt_speed_q);
    e21      = 21'(err_q);
    f21      = 21'(filt_err_q);
    num_calc = (e21 <<< 1) + e21 + (f21 <<< 3) - f21;
    isum     = 19'(err_int_q) + 19'(filt_err_q);
    if (isum > INT_MAX) begin
      isum = INT_MAX;
    end else if (isum < -INT_MAX) begin
      isum = -INT_MAX;
    end
    int_calc = stop_q ? '0 : 15'(isum);
  end

  // Drop the fraction bits, rounding negative results up toward zero
  always_comb begin
    v_calc = prod_a[52:16] + 37'(prod_a[PW-1] & (|prod_a[15:0]));
    t_calc = prod_b[49:16] + 34'(prod_b[PW-1] & (|prod_b[15:0]));
    u_calc = prod_a[64:24] + 41'(prod_a[PW-1] & (|prod_a[23:0]));
  end

  // Upright setpoint shifted by the velocity output, angle error saturated
  always_comb begin
    setpoint = $signed({{2{v_q[36]}}, v_q, 8'b0}) + 47'(bal_angle_q);
    dd       = 47'(pitch_q) - setpoint;
    if (dd > DIFF_MAX) begin
      dd = DIFF_MAX;
    end else if (dd < -DIFF_MAX) begin
      dd = -DIFF_MAX;
    end
    diff_calc = 32'(dd);
  end

  // Motor mix: upright minus / plus turn, each clamped to the drive limit
  always_comb begin
    mix_u      = 42'(u_q);
    mix_t      = 42'(t_q);
    mix_lim    = $signed({26'b0, pwm_limit_q});
    left_calc  = 17'(clamp_lim(mix_u - mix_t, mix_lim));
    right_calc = 17'(clamp_lim(mix_u + mix_t, mix_lim));
  end

  // Multiply-accumulate operands: unit A runs velocity then upright, B turn
  always_comb begin
    if (state_q == brcc_pkg::ST_U_GO) begin
      mac_a_op.xa = diff_q;
      mac_a_op.ga = upright_kp_q;
      mac_a_op.xb = 32'($signed({rate_pitch_q, 8'b0}));
      mac_a_op.gb = upright_kd_q;
    end else begin
      mac_a_op.xa = 32'(filt_err_q);
      mac_a_op.ga = speed_kp_q;
      mac_a_op.xb = 32'(err_int_q);
      mac_a_op.gb = speed_ki_q;
    end
    // Apply yaw damping only while no turn command is given
    mac_b_op.xa = 32'(rate_yaw_q);
    mac_b_op.ga = turn_cmd_q ? '0 : steer_kd_q;
    mac_b_op.xb = 32'(turn_speed_q);
    mac_b_op.gb = steer_kp_q;
  end

  // ------------------------------------------------------------------
  // Sequencer
  // ------------------------------------------------------------------
  assign in_req = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d      = state_q;
    tgt_speed_d  = tgt_speed_q;
    turn_speed_d = turn_speed_q;
    filt_err_d   = filt_err_q;
    err_int_d    = err_int_q;
    div_start    = 1'b0;
    mac_a_start  = 1'b0;
    mac_b_start  = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      brcc_pkg::ST_IDLE: begin
        if (in_req) begin
          tgt_speed_d  = tgt_next;
          turn_speed_d = turn_next;
          state_d      = brcc_pkg::ST_ERR;
        end
      end
      brcc_pkg::ST_ERR:    state_d = brcc_pkg::ST_NUM;
      brcc_pkg::ST_NUM:    state_d = brcc_pkg::ST_DIV_GO;
      brcc_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = brcc_pkg::ST_DIV_RUN;
      end
      brcc_pkg::ST_DIV_RUN: begin
        if (div_done) begin
          filt_err_d = div_quot;
          state_d    = brcc_pkg::ST_INTG;
        end
      end
      brcc_pkg::ST_INTG: begin
        err_int_d = int_calc;
        state_d   = brcc_pkg::ST_VT_GO;
      end
      brcc_pkg::ST_VT_GO: begin
        mac_a_start = 1'b1;
        mac_b_start = 1'b1;
        state_d     = brcc_pkg::ST_VT_RUN;
      end
      brcc_pkg::ST_VT_RUN: begin
        if (mac_a_done && mac_b_done) begin
          state_d = brcc_pkg::ST_DIFF;
        end
      end
      brcc_pkg::ST_DIFF:   state_d = brcc_pkg::ST_U_GO;
      brcc_pkg::ST_U_GO: begin
        mac_a_start = 1'b1;
        state_d     = brcc_pkg::ST_U_RUN;
      end
      brcc_pkg::ST_U_RUN: begin
        if (mac_a_done) begin
          state_d = brcc_pkg::ST_MIX;
        end
      end
      brcc_pkg::ST_MIX: begin
        // Hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = brcc_pkg::ST_IDLE;
        end
      end
      default: state_d = brcc_pkg::ST_IDLE;
    endcase
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= brcc_pkg::ST_IDLE;
      tgt_speed_q  <= '0;
      turn_speed_q <= '0;
      filt_err_q   <= '0;
      err_int_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      tgt_speed_q  <= tgt_speed_d;
      turn_speed_q <= turn_speed_d;
      filt_err_q   <= filt_err_d;
      err_int_q    <= err_int_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bal_angle_q  <= 17'(brcc_pkg::BAL_ANGLE_RST);
      upright_kp_q <= brcc_pkg::UPRIGHT_KP_RST;
      upright_kd_q <= brcc_pkg::UPRIGHT_KD_RST;
      speed_kp_q   <= brcc_pkg::SPEED_KP_RST;
      speed_ki_q   <= brcc_pkg::SPEED_KI_RST;
      steer_kp_q   <= brcc_pkg::STEER_KP_RST;
      steer_kd_q   <= brcc_pkg::STEER_KD_RST;
      pwm_limit_q  <= brcc_pkg::PWM_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (brcc_pkg::cfg_idx_e'(cfg_addr_i))
        brcc_pkg::CFG_BALANCE_ANGLE: bal_angle_q  <= cfg_wdata_i[16:0];
        brcc_pkg::CFG_UPRIGHT_KP:    upright_kp_q <= cfg_wdata_i;
        brcc_pkg::CFG_UPRIGHT_KD:    upright_kd_q <= cfg_wdata_i;
        brcc_pkg::CFG_SPEED_KP:      speed_kp_q   <= cfg_wdata_i;
        brcc_pkg::CFG_SPEED_KI:      speed_ki_q   <= cfg_wdata_i;
        brcc_pkg::CFG_STEER_KP:      steer_kp_q   <= cfg_wdata_i;
        brcc_pkg::CFG_STEER_KD:      steer_kd_q   <= cfg_wdata_i;
        brcc_pkg::CFG_PWM_LIMIT:     pwm_limit_q  <= cfg_wdata_i[15:0];
      endcase
    end
  end

  // Payload registers, loaded by sequencer step
  always_ff @(posedge clk_i) begin
    if (in_req) begin
      enc_left_q   <= in_enc_left;
      enc_right_q  <= in_enc_right;
      pitch_q      <= in_pitch;
      rate_pitch_q <= in_rate_pitch;
      rate_yaw_q   <= in_rate_yaw;
      turn_cmd_q   <= in_left || in_right;
      stop_q       <= in_stop;
    end
    if (state_q == brcc_pkg::ST_ERR) begin
      err_q <= err_calc;
    end
    if (state_q == brcc_pkg::ST_NUM) begin
      num_q <= num_calc;
    end
    if (state_q == brcc_pkg::ST_VT_RUN && mac_a_done && mac_b_done) begin
      v_q <= v_calc;
      t_q <= t_calc;
    end
    if (state_q == brcc_pkg::ST_DIFF) begin
      diff_q <= diff_calc;
    end
    if (state_q == brcc_pkg::ST_U_RUN && mac_a_done) begin
      u_q <= u_calc;
    end
    if (out_load) begin
      drive_left_q  <= left_calc;
      drive_right_q <= right_calc;
    end
  end

  // ------------------------------------------------------------------
  // Arithmetic units
  // ------------------------------------------------------------------
  brcc_div10 u_div10 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  brcc_mac u_mac_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_a_start),
    .op_i    (mac_a_op),
    .done_o  (mac_a_done),
    .prod_o  (prod_a)
  );

  brcc_mac u_mac_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_b_start),
    .op_i    (mac_b_op),
    .done_o  (mac_b_done),
    .prod_o  (prod_b)
  );

  assign s_axis_tready = (state_q == brcc_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, drive_right_q, drive_left_q};

`ifndef SYNTHESIS
  a_tgt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tgt_speed_q <= brcc_pkg::SPEED_FWD_MAX) && (tgt_speed_q >= -brcc_pkg::SPEED_FWD_MAX))
    else $error("forward target left its range");

  a_turn_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (turn_speed_q <= brcc_pkg::SPEED_TURN_MAX) &&
    (turn_speed_q >= -brcc_pkg::SPEED_TURN_MAX))
    else $error("turn target left its range");

  a_int_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_int_q <= brcc_pkg::INTEGRAL_MAX) && (err_int_q >= -brcc_pkg::INTEGRAL_MAX))
    else $error("velocity integral left its range");

  a_drive_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (drive_left_q <= $signed({1'b0, pwm_limit_q})) &&
      (drive_left_q >= -$signed({1'b0, pwm_limit_q})) &&
      (drive_right_q <= $signed({1'b0, pwm_limit_q})) &&
      (drive_right_q >= -$signed({1'b0, pwm_limit_q})))
    else $error("motor drive beyond the drive limit");

  a_unit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_done || mac_a_done || mac_b_done) |->
      ((div_done && state_q == brcc_pkg::ST_DIV_RUN) ||
       (mac_a_done && state_q == brcc_pkg::ST_VT_RUN) ||
       (mac_a_done && state_q == brcc_pkg::ST_U_RUN)))
    else $error("arithmetic unit finished outside its sequencer step");
`endif

endmodule
